FILE: rtl/mfde_pkg.sv
// Shared types and constants for the monochrome frame-store draw engine.
// Used by the controller, the datapath and the top level.
package mfde_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 256;
    localparam int BUFFER_BYTES = 4096;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);

    typedef enum logic [2:0] {
        FN_CLEAR  = 3'd0,
        FN_SET    = 3'd1,
        FN_READ   = 3'd2,
        FN_HLINE  = 3'd3,
        FN_VLINE  = 3'd4,
        FN_RECT   = 3'd5,
        FN_FILL   = 3'd6,
        FN_NONE   = 3'd7
    } func_t;

    localparam logic [1:0] REG_FLIP_X = 2'd0;
    localparam logic [1:0] REG_FLIP_Y = 2'd1;
    localparam logic [1:0] REG_BLACK  = 2'd2;
    localparam logic [1:0] REG_WHITE  = 2'd3;

    // Controller to datapath.
    typedef struct packed {
        logic        rd;       // read the byte at pixel (px, py)
        logic        wr;       // write back the modified byte
        logic        wr_fill;  // write fill byte at fill_addr
        logic [ADDR_W-1:0] fill_addr;
        logic [15:0] px;
        logic [15:0] py;
        logic [7:0]  ink;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic        hit;      // last looked-up pixel is set
    } dp_stat_t;

endpackage

FILE: rtl/mono_framebuffer_draw_engine.sv
// Monochrome frame-store draw engine, top level; uses mfde_pkg, mfde_ctrl, mfde_datapath.
// Set pixel, lines and rectangles read and write back each pixel drawn, walking one
// segment or panel row at a time. One request at a time: the next is taken only once
// the previous result has been accepted.
// Reset: a clearing pass zeroes the store; no request is taken until it ends.
module mono_framebuffer_draw_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[2:0], x_a[18:3], x_b[34:19], y_a[50:35], y_b[66:51],
    // rect_width[82:67], rect_height[98:83], ink[106:99], zero pad
    input  logic [111:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_value[7:0], op_done[8], zero pad
    output logic [15:0] m_tdata
);

    logic       flip_x_reg, flip_y_reg;
    logic [7:0] black_reg, white_reg;
    logic [7:0] pixel_value;
    mfde_pkg::dp_cmd_t  cmd;
    mfde_pkg::dp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_x_reg <= 1'b1;
            flip_y_reg <= 1'b0;
            black_reg  <= 8'hFF;
            white_reg  <= 8'h00;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mfde_pkg::REG_FLIP_X: flip_x_reg <= cfg_data[0];
                mfde_pkg::REG_FLIP_Y: flip_y_reg <= cfg_data[0];
                mfde_pkg::REG_BLACK:  black_reg  <= cfg_data;
                default:              white_reg  <= cfg_data;
            endcase
        end
    end

    mfde_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .func        (s_tdata[2:0]),
        .x_a         (s_tdata[18:3]),
        .x_b         (s_tdata[34:19]),
        .y_a         (s_tdata[50:35]),
        .y_b         (s_tdata[66:51]),
        .rect_width  (s_tdata[82:67]),
        .rect_height (s_tdata[98:83]),
        .ink         (s_tdata[106:99]),
        .black_code  (black_reg),
        .white_code  (white_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .pixel_value (pixel_value),
        .cmd         (cmd),
        .stat        (stat)
    );

    mfde_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .flip_x     (flip_x_reg),
        .flip_y     (flip_y_reg),
        .black_code (black_reg),
        .cmd        (cmd),
        .stat       (stat)
    );

    assign m_tdata = {7'd0, 1'b1, pixel_value};

    a_no_fill_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_fill && cmd.wr))
        else $error("fill and pixel write in the same cycle");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken twice back to back");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> $past(cmd.rd))
        else $error("pixel write without preceding read");

endmodule

FILE: rtl/mfde_datapath.sv
// Frame store with pixel addressing, read-modify-write and fill.
// Depends on mfde_pkg.
module mfde_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               flip_x,
    input  logic               flip_y,
    input  logic [7:0]         black_code,
    input  mfde_pkg::dp_cmd_t  cmd,
    output mfde_pkg::dp_stat_t stat
);

    localparam int XW = $clog2(mfde_pkg::PANEL_WIDTH);
    localparam int YW = $clog2(mfde_pkg::PANEL_HEIGHT);
    localparam int IW = XW + YW;

    logic [7:0] mem [mfde_pkg::BUFFER_BYTES];

    logic [15:0] rx, ry;
    logic        on_panel;
    logic [IW-1:0] bit_idx;
    logic [IW-1:0] byte_idx;
    logic [7:0]  mask;

    logic [7:0]  rdata_reg;
    logic [mfde_pkg::ADDR_W-1:0] addr_reg;
    logic [7:0]  mask_reg;
    logic        ok_reg;

    always_comb
    begin
        rx = flip_x ? 16'(mfde_pkg::PANEL_WIDTH - 1) - cmd.px : cmd.px;
        ry = flip_y ? 16'(mfde_pkg::PANEL_HEIGHT - 1) - cmd.py : cmd.py;
        bit_idx  = {rx[XW-1:0], ry[YW-1:0]};
        byte_idx = bit_idx >> 3;
        on_panel = (32'(rx) < 32'(mfde_pkg::PANEL_WIDTH))
                && (32'(ry) < 32'(mfde_pkg::PANEL_HEIGHT))
                && (32'(byte_idx) < 32'(mfde_pkg::BUFFER_BYTES));
        mask = 8'h80 >> ry[2:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rdata_reg <= mem[byte_idx[mfde_pkg::ADDR_W-1:0]];
            addr_reg  <= byte_idx[mfde_pkg::ADDR_W-1:0];
            mask_reg  <= mask;
        end
        if (cmd.wr_fill)
            mem[cmd.fill_addr] <= cmd.ink;
        else if (cmd.wr && ok_reg)
            mem[addr_reg] <= (cmd.ink == black_code) ? (rdata_reg | mask_reg)
                                                     : (rdata_reg & ~mask_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ok_reg <= 1'b0;
        else if (cmd.rd)
            ok_reg <= on_panel;
    end

    assign stat.hit = ok_reg && ((rdata_reg & mask_reg) != 8'd0);

endmodule

FILE: rtl/mfde_ctrl.sv
// Command sequencer: clearing pass, pixel walks over lines, rectangles and fills, and pixel reads.
// Depends on mfde_pkg; drives mfde_datapath through dp_cmd_t.
module mfde_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [2:0]         func,
    input  logic [15:0]        x_a,
    input  logic [15:0]        x_b,
    input  logic [15:0]        y_a,
    input  logic [15:0]        y_b,
    input  logic [15:0]        rect_width,
    input  logic [15:0]        rect_height,
    input  logic [7:0]         ink,
    input  logic [7:0]         black_code,
    input  logic [7:0]         white_code,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         pixel_value,
    output mfde_pkg::dp_cmd_t  cmd,
    input  mfde_pkg::dp_stat_t stat
);

    localparam logic [15:0] XMAX = 16'(mfde_pkg::PANEL_WIDTH - 1);
    localparam logic [15:0] YMAX = 16'(mfde_pkg::PANEL_HEIGHT - 1);
    localparam int AW = mfde_pkg::ADDR_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FILL, S_SEG, S_PRD, S_PWR, S_READ, S_RDONE,
        S_NEXT, S_DONE
    } state_t;

    state_t state_reg;
    logic [AW-1:0] fa_reg;
    logic [AW:0]   fcnt_reg;
    logic [2:0]    func_reg;
    logic [15:0]   xa_reg, xb_reg, ya_reg, yb_reg, rt_reg, bt_reg, h_reg;
    logic [7:0]    ink_reg;
    logic [2:0]    seg_reg;      // outline part of a rectangle
    logic [15:0]   row_reg;      // fill row
    logic          vert_reg;     // walking along y
    logic [15:0]   fix_reg;      // fixed coordinate
    logic [15:0]   cur_reg, end_reg;
    logic [7:0]    pv_reg;
    logic          ov_reg;
    logic          last_seg;

    // segment setup for current seg_reg
    logic        sv, sskip;
    logic [15:0] sfix, s0, s1, lo, hi, lim;

    always_comb
    begin
        sv = 1'b0;
        sfix = ya_reg;
        s0 = xa_reg;
        s1 = xb_reg;
        last_seg = 1'b1;
        unique case (func_reg)
            mfde_pkg::FN_HLINE: ;
            mfde_pkg::FN_VLINE:
            begin
                sv = 1'b1; sfix = xa_reg; s0 = ya_reg; s1 = yb_reg;
            end
            mfde_pkg::FN_RECT:
            begin
                last_seg = (seg_reg == 3'd3);
                unique case (seg_reg[1:0])
                    2'd0: begin sfix = ya_reg; s1 = rt_reg; end
                    2'd1: begin sfix = bt_reg; s1 = rt_reg; end
                    2'd2: begin sv = 1'b1; sfix = xa_reg; s0 = ya_reg; s1 = bt_reg; end
                    default: begin sv = 1'b1; sfix = rt_reg; s0 = ya_reg; s1 = bt_reg; end
                endcase
            end
            default:
            begin
                sfix = row_reg; s1 = rt_reg;
                last_seg = (row_reg == YMAX);
            end
        endcase
        lim = sv ? YMAX : XMAX;
        lo = (s0 > s1) ? s1 : s0;
        hi = (s0 > s1) ? s0 : s1;
        if (lo > lim) lo = lim;
        if (hi > lim) hi = lim;
        sskip = (sfix > (sv ? XMAX : YMAX));
        if (func_reg == mfde_pkg::FN_FILL && ((row_reg - ya_reg) >= h_reg))
            sskip = 1'b1;
    end

    always_comb
    begin
        cmd = '0;
        cmd.ink = ink_reg;
        cmd.fill_addr = fa_reg;
        cmd.px = vert_reg ? fix_reg : cur_reg;
        cmd.py = vert_reg ? cur_reg : fix_reg;
        if (func_reg == mfde_pkg::FN_READ)
        begin
            cmd.px = xa_reg;
            cmd.py = ya_reg;
        end
        cmd.wr_fill = (state_reg == S_INIT) || (state_reg == S_FILL);
        if (state_reg == S_INIT)
            cmd.ink = 8'd0;
        cmd.rd = (state_reg == S_PRD) || (state_reg == S_READ);
        cmd.wr = (state_reg == S_PWR);
    end

    assign s_tready    = (state_reg == S_IDLE) && !ov_reg;
    assign m_tvalid    = ov_reg;
    assign pixel_value = pv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            fa_reg    <= '0;
            fcnt_reg  <= '0;
            ov_reg    <= 1'b0;
            pv_reg    <= '0;
            func_reg  <= '0;
            seg_reg   <= '0;
            row_reg   <= '0;
            vert_reg  <= 1'b0;
            xa_reg    <= '0;
            xb_reg    <= '0;
            ya_reg    <= '0;
            yb_reg    <= '0;
            rt_reg    <= '0;
            bt_reg    <= '0;
            h_reg     <= '0;
            ink_reg   <= '0;
            fix_reg   <= '0;
            cur_reg   <= '0;
            end_reg   <= '0;
        end
        else
        begin
            if (ov_reg && m_tready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_INIT, S_FILL:
                begin
                    fa_reg   <= fa_reg + 1'b1;
                    fcnt_reg <= fcnt_reg + 1'b1;
                    if (fcnt_reg == (AW+1)'(mfde_pkg::BUFFER_BYTES - 1))
                        state_reg <= (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        func_reg <= func;
                        xa_reg <= x_a; xb_reg <= x_b; ya_reg <= y_a; yb_reg <= y_b;
                        rt_reg <= x_a + rect_width - 16'd1;
                        bt_reg <= y_a + rect_height - 16'd1;
                        h_reg  <= rect_height;
                        ink_reg <= ink;
                        seg_reg <= '0;
                        row_reg <= '0;
                        fa_reg <= '0;
                        fcnt_reg <= '0;
                        unique case (mfde_pkg::func_t'(func))
                            mfde_pkg::FN_CLEAR: state_reg <= S_FILL;
                            mfde_pkg::FN_SET:
                            begin
                                vert_reg <= 1'b0; cur_reg <= x_a; fix_reg <= y_a;
                                end_reg <= x_a; state_reg <= S_PRD;
                            end
                            mfde_pkg::FN_READ: state_reg <= S_READ;
                            mfde_pkg::FN_HLINE, mfde_pkg::FN_VLINE,
                            mfde_pkg::FN_RECT, mfde_pkg::FN_FILL: state_reg <= S_SEG;
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_SEG:
                begin
                    vert_reg <= sv;
                    fix_reg  <= sfix;
                    cur_reg  <= lo;
                    end_reg  <= hi;
                    state_reg <= sskip ? S_NEXT : S_PRD;
                end
                S_PRD: state_reg <= S_PWR;
                S_PWR:
                begin
                    if (cur_reg == end_reg)
                        state_reg <= (func_reg == mfde_pkg::FN_SET) ? S_DONE : S_NEXT;
                    else
                    begin
                        cur_reg <= cur_reg + 16'd1;
                        state_reg <= S_PRD;
                    end
                end
                S_NEXT:
                begin
                    if (last_seg)
                        state_reg <= S_DONE;
                    else
                    begin
                        seg_reg <= seg_reg + 3'd1;
                        row_reg <= row_reg + 16'd1;
                        state_reg <= S_SEG;
                    end
                end
                S_READ: state_reg <= S_RDONE;
                S_RDONE:
                begin
                    pv_reg <= stat.hit ? black_code : white_code;
                    ov_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_DONE:
                begin
                    pv_reg <= white_code;
                    ov_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for mono_framebuffer_draw_engine: an in-bench draw predictor
// mirrors the frame store and checks every returned pixel value and done flag.
// Depends on mfde_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int unsigned HOLD_LEN = 3000;

    typedef struct packed {
        logic [7:0]  ink;
        logic [15:0] rect_height;
        logic [15:0] rect_width;
        logic [15:0] y_b;
        logic [15:0] y_a;
        logic [15:0] x_b;
        logic [15:0] x_a;
        mfde_pkg::func_t func;
    } draw_req_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [7:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;

    mono_framebuffer_draw_engine uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor state
    logic [7:0]  pix_store [mfde_pkg::BUFFER_BYTES];
    logic        mir_x;
    logic        mir_y;
    logic [7:0]  black_ink;
    logic [7:0]  white_ink;
    logic [7:0]  pixel_q [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_epoch = 0;     // bump to start a long receiver hold-off
    int unsigned seen_epoch = 0;
    int unsigned hold_left = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit locate(input int unsigned x, input int unsigned y,
                                  output int unsigned idx, output logic [7:0] mask);
        int unsigned rx;
        int unsigned ry;
        rx = mir_x ? ((mfde_pkg::PANEL_WIDTH - 1) - x) & 32'hFFFF : x;
        ry = mir_y ? ((mfde_pkg::PANEL_HEIGHT - 1) - y) & 32'hFFFF : y;
        idx = 0;
        mask = 8'h00;
        if (rx >= mfde_pkg::PANEL_WIDTH || ry >= mfde_pkg::PANEL_HEIGHT)
            return 1'b0;
        idx = (rx * mfde_pkg::PANEL_HEIGHT + ry) / 8;
        if (idx >= mfde_pkg::BUFFER_BYTES)
            return 1'b0;
        mask = 8'h80 >> (ry % 8);
        return 1'b1;
    endfunction

    function automatic void plot(input int unsigned x, input int unsigned y,
                                 input logic [7:0] ink);
        int unsigned idx;
        logic [7:0] mask;
        if (!locate(x & 32'hFFFF, y & 32'hFFFF, idx, mask))
            return;
        if (ink == black_ink)
            pix_store[idx] = pix_store[idx] | mask;
        else
            pix_store[idx] = pix_store[idx] & ~mask;
    endfunction

    function automatic void draw_row(input int unsigned x0, input int unsigned x1,
                                     input int unsigned y, input logic [7:0] ink);
        int unsigned t;
        x0 &= 32'hFFFF; x1 &= 32'hFFFF; y &= 32'hFFFF;
        if (y >= mfde_pkg::PANEL_HEIGHT)
            return;
        if (x0 > x1)
        begin
            t = x0; x0 = x1; x1 = t;
        end
        if (x0 >= mfde_pkg::PANEL_WIDTH) x0 = mfde_pkg::PANEL_WIDTH - 1;
        if (x1 >= mfde_pkg::PANEL_WIDTH) x1 = mfde_pkg::PANEL_WIDTH - 1;
        for (int unsigned x = x0; x <= x1; x++)
            plot(x, y, ink);
    endfunction

    function automatic void draw_col(input int unsigned x, input int unsigned y0,
                                     input int unsigned y1, input logic [7:0] ink);
        int unsigned t;
        x &= 32'hFFFF; y0 &= 32'hFFFF; y1 &= 32'hFFFF;
        if (x >= mfde_pkg::PANEL_WIDTH)
            return;
        if (y0 > y1)
        begin
            t = y0; y0 = y1; y1 = t;
        end
        if (y0 >= mfde_pkg::PANEL_HEIGHT) y0 = mfde_pkg::PANEL_HEIGHT - 1;
        if (y1 >= mfde_pkg::PANEL_HEIGHT) y1 = mfde_pkg::PANEL_HEIGHT - 1;
        for (int unsigned y = y0; y <= y1; y++)
            plot(x, y, ink);
    endfunction

    // Apply one request to the shadow store and return the expected pixel value.
    function automatic logic [7:0] draw_and_read(input draw_req_t req);
        int unsigned right;
        int unsigned bottom;
        int unsigned idx;
        logic [7:0]  mask;
        logic [7:0]  value;
        value = white_ink;
        right = (req.x_a + req.rect_width - 1) & 32'hFFFF;
        bottom = (req.y_a + req.rect_height - 1) & 32'hFFFF;
        case (req.func)
            mfde_pkg::FN_CLEAR:
                for (int i = 0; i < mfde_pkg::BUFFER_BYTES; i++)
                    pix_store[i] = req.ink;
            mfde_pkg::FN_SET:   plot(req.x_a, req.y_a, req.ink);
            mfde_pkg::FN_READ:
                if (locate(req.x_a, req.y_a, idx, mask) && (pix_store[idx] & mask) != 0)
                    value = black_ink;
            mfde_pkg::FN_HLINE: draw_row(req.x_a, req.x_b, req.y_a, req.ink);
            mfde_pkg::FN_VLINE: draw_col(req.x_a, req.y_a, req.y_b, req.ink);
            mfde_pkg::FN_RECT:
            begin
                draw_row(req.x_a, right, req.y_a, req.ink);
                draw_row(req.x_a, right, bottom, req.ink);
                draw_col(req.x_a, req.y_a, bottom, req.ink);
                draw_col(right, req.y_a, bottom, req.ink);
            end
            mfde_pkg::FN_FILL:
                // a panel row is hit when its wrapped offset from y_a is below the height
                for (int unsigned r = 0; r < mfde_pkg::PANEL_HEIGHT; r++)
                    if (((r - req.y_a) & 32'hFFFF) < req.rect_height)
                        draw_row(req.x_a, right, r, req.ink);
            default: ;
        endcase
        return value;
    endfunction

    // Send one request; returns with s_tvalid still high after acceptance.
    task automatic send_request(input draw_req_t req);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, req};
        do
            @(posedge clk);
        while (!s_tready);
        pixel_q.push_back(draw_and_read(req));
    endtask

    task automatic go_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pixel_q.size() == 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        go_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mfde_pkg::REG_FLIP_X: mir_x = value[0];
            mfde_pkg::REG_FLIP_Y: mir_y = value[0];
            mfde_pkg::REG_BLACK:  black_ink = value;
            default:              white_ink = value;
        endcase
    endtask

    task automatic set_regs(input logic mx, input logic my, input logic [7:0] blk,
                            input logic [7:0] wht);
        write_reg(mfde_pkg::REG_FLIP_X, {7'b0, mx});
        write_reg(mfde_pkg::REG_FLIP_Y, {7'b0, my});
        write_reg(mfde_pkg::REG_BLACK, blk);
        write_reg(mfde_pkg::REG_WHITE, wht);
    endtask

    function automatic draw_req_t make_req(input mfde_pkg::func_t f, input int unsigned xa,
        input int unsigned xb, input int unsigned ya, input int unsigned yb,
        input int unsigned w, input int unsigned h, input logic [7:0] ink);
        draw_req_t r;
        r.func = f; r.x_a = 16'(xa); r.x_b = 16'(xb); r.y_a = 16'(ya); r.y_b = 16'(yb);
        r.rect_width = 16'(w); r.rect_height = 16'(h); r.ink = ink;
        return r;
    endfunction

    function automatic logic [15:0] rand_coord(input int unsigned span);
        case ($urandom_range(9))
            0:       return 16'($urandom_range(65535));
            1:       return 16'(32'hFFFF - $urandom_range(8));
            default: return 16'($urandom_range(span + 8));
        endcase
    endfunction

    function automatic draw_req_t rand_req();
        draw_req_t r;
        int unsigned pick;
        r.x_a = rand_coord(mfde_pkg::PANEL_WIDTH);
        r.x_b = rand_coord(mfde_pkg::PANEL_WIDTH);
        r.y_a = rand_coord(mfde_pkg::PANEL_HEIGHT);
        r.y_b = rand_coord(mfde_pkg::PANEL_HEIGHT);
        r.rect_width  = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                                 : 16'($urandom_range(12));
        r.rect_height = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                                 : 16'($urandom_range(12));
        r.ink = ($urandom_range(1) == 0) ? black_ink : 8'($urandom_range(255));
        pick = $urandom_range(199);
        if (pick < 2)
            r.func = mfde_pkg::FN_CLEAR;
        else if (pick < 8)
        begin
            r.func = mfde_pkg::FN_FILL;
            // keep most fills small; a big one walks the whole panel
            if ($urandom_range(24) != 0)
            begin
                r.rect_width  = 16'($urandom_range(10));
                r.rect_height = 16'($urandom_range(10));
            end
        end
        else if (pick < 10)
            r.func = mfde_pkg::FN_NONE;
        else if (pick < 30)
            r.func = mfde_pkg::FN_RECT;
        else if (pick < 55)
            r.func = mfde_pkg::FN_HLINE;
        else if (pick < 80)
            r.func = mfde_pkg::FN_VLINE;
        else if (pick < 140)
            r.func = mfde_pkg::FN_SET;
        else
            r.func = mfde_pkg::FN_READ;
        return r;
    endfunction

    task automatic test_directed();
        send_request(make_req(mfde_pkg::FN_READ, 0, 0, 0, 0, 0, 0, 8'h00));
        send_request(make_req(mfde_pkg::FN_SET, 0, 0, 0, 0, 0, 0, 8'hFF));
        send_request(make_req(mfde_pkg::FN_SET, 127, 0, 255, 0, 0, 0, 8'hFF));
        send_request(make_req(mfde_pkg::FN_READ, 0, 0, 0, 0, 0, 0, 8'h00));
        send_request(make_req(mfde_pkg::FN_READ, 127, 0, 255, 0, 0, 0, 8'h00));
        // off-panel writes and reads
        send_request(make_req(mfde_pkg::FN_SET, 128, 0, 256, 0, 0, 0, 8'hFF));
        send_request(make_req(mfde_pkg::FN_READ, 16'hFFFF, 0, 16'hFFFF, 0, 0, 0, 8'h00));
        send_request(make_req(mfde_pkg::FN_READ, 128, 0, 3, 0, 0, 0, 8'h00));
        // reversed and clamped lines
        send_request(make_req(mfde_pkg::FN_HLINE, 100, 5, 7, 0, 0, 0, 8'hFF));
        send_request(make_req(mfde_pkg::FN_HLINE, 300, 200, 9, 0, 0, 0, 8'hFF));
        send_request(make_req(mfde_pkg::FN_HLINE, 0, 10, 256, 0, 0, 0, 8'hFF));
        send_request(make_req(mfde_pkg::FN_VLINE, 3, 0, 250, 2, 0, 0, 8'hFF));
        send_request(make_req(mfde_pkg::FN_VLINE, 4, 0, 16'hFFFF, 400, 0, 0, 8'hFF));
        send_request(make_req(mfde_pkg::FN_VLINE, 128, 0, 0, 10, 0, 0, 8'hFF));
        // rectangles: zero width wraps, zero height; fills: zero height, bottom wrapping
        send_request(make_req(mfde_pkg::FN_RECT, 10, 0, 20, 0, 5, 6, 8'hFF));
        send_request(make_req(mfde_pkg::FN_RECT, 30, 0, 40, 0, 0, 3, 8'hFF));
        send_request(make_req(mfde_pkg::FN_RECT, 50, 0, 60, 0, 4, 0, 8'hFF));
        send_request(make_req(mfde_pkg::FN_FILL, 60, 0, 70, 0, 6, 0, 8'hFF));
        send_request(make_req(mfde_pkg::FN_FILL, 60, 0, 16'hFFF8, 0, 5, 14, 8'hFF));
        send_request(make_req(mfde_pkg::FN_FILL, 20, 0, 20, 0, 4, 4, 8'h12));
        send_request(make_req(mfde_pkg::FN_READ, 22, 0, 22, 0, 0, 0, 8'h00));
        send_request(make_req(mfde_pkg::FN_NONE, 0, 0, 0, 0, 0, 0, 8'hFF));
        send_request(make_req(mfde_pkg::FN_CLEAR, 0, 0, 0, 0, 0, 0, 8'hA5));
        send_request(make_req(mfde_pkg::FN_READ, 5, 0, 2, 0, 0, 0, 8'h00));
        send_request(make_req(mfde_pkg::FN_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 8'h00));
    endtask

    task automatic test_random(input int unsigned count, input int unsigned idle_pct,
                               input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            // toggle between free-running and throttled stretches
            if (i % 60 == 30)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else if (i % 60 == 0)
            begin
                send_idle_pct  = idle_pct;
                recv_stall_pct = stall_pct;
            end
            send_request(rand_req());
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_epoch++;
        for (int i = 0; i < 40; i++)
            send_request(make_req(($urandom_range(1) == 0) ? mfde_pkg::FN_READ
                                                          : mfde_pkg::FN_SET,
                                  $urandom_range(127), 0, $urandom_range(255), 0, 0, 0,
                                  black_ink));
    endtask

    // result receiver: long hold-off countdown and random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_epoch != seen_epoch)
        begin
            seen_epoch <= hold_epoch;
            hold_left  <= HOLD_LEN - 1;
            m_tready   <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pixel_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (m_tdata[7:0] !== want || m_tdata[8] !== 1'b1)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pixel_value exp %h got %h, op_done exp 1 got %b",
                                 want, m_tdata[7:0], m_tdata[8]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("mono_framebuffer_draw_engine verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mir_x = 1'b1;
        mir_y = 1'b0;
        black_ink = 8'hFF;
        white_ink = 8'h00;
        for (int i = 0; i < mfde_pkg::BUFFER_BYTES; i++)
            pix_store[i] = 8'h00;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        set_regs(1'b0, 1'b1, 8'h00, 8'hFF);
        test_directed();
        set_regs(1'b0, 1'b0, 8'h5A, 8'h3C);
        test_random(240, 0, 0);
        set_regs(1'b1, 1'b1, 8'hFF, 8'h00);
        test_random(240, 81, 0);
        set_regs(1'b1, 1'b0, 8'h80, 8'h80);
        test_random(240, 0, 81);
        test_backpressure();
        set_regs(1'b0, 1'b1, 8'h01, 8'hFE);
        test_random(240, 23, 23);
        go_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("mono_framebuffer_draw_engine verification clean");
        else
            $display("mono_framebuffer_draw_engine verification failed");
        $finish;
    end
endmodule

FILE: files.f
rtl/mfde_pkg.sv
rtl/mfde_datapath.sv
rtl/mfde_ctrl.sv
rtl/mono_framebuffer_draw_engine.sv
bench/tb_top.sv
